// ----- sv/oversampled_mode_frame_receiver_unit_defines.svh -----
// assertion macros for the mode frame receiver
`ifndef OVERSAMPLED_MODE_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define OVERSAMPLED_MODE_FRAME_RECEIVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define OMFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("omfr: same-cycle check failed");
`define OMFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("omfr: next-cycle check failed");
`else
`define OMFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OMFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/omfr_pkg.sv -----
// shared types, constants and code decode for the mode frame receiver
package omfr_pkg;

    localparam int unsigned GAP_W  = 7;
    localparam int unsigned CODE_W = 8;
    localparam int unsigned MODE_W = 3;

    localparam logic [GAP_W-1:0] FRAME_BITS      = 7'd5;
    localparam logic [GAP_W-1:0] FRAME_GAP_RESET = 7'd18;
    localparam logic [GAP_W-1:0] ERROR_GAP_RESET = 7'd108;

    localparam logic [3:0] DECIDE_PHASE = 4'd3;
    localparam logic [3:0] ABORT_PHASE  = 4'd2;
    localparam logic [3:0] BIT_TICKS    = 4'd8;
    localparam logic [1:0] ALL_HIGH     = 2'b11;

    localparam logic [CODE_W-1:0] CODE_MODE0 = 8'h02;
    localparam logic [CODE_W-1:0] CODE_MODE1 = 8'h04;
    localparam logic [CODE_W-1:0] CODE_MODE2 = 8'h06;
    localparam logic [CODE_W-1:0] CODE_MODE3 = 8'h08;
    localparam logic [CODE_W-1:0] CODE_MODE4 = 8'h0a;
    localparam logic [CODE_W-1:0] CODE_WAKE  = 8'h0e;

    localparam logic [MODE_W-1:0] MODE_MAX = 3'd4;

    // register indexes
    localparam logic CFG_FRAME_GAP = 1'b0;
    localparam logic CFG_ERROR_GAP = 1'b1;

    typedef struct packed {
        logic [GAP_W-1:0] frame_gap;
        logic [GAP_W-1:0] error_gap;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              wake;
        logic              frame_done;
        logic              bit_error;
        logic [CODE_W-1:0] received_code;
    } t_result;

    function automatic logic [MODE_W-1:0] f_decode_mode(input logic [CODE_W-1:0] code,
                                                        input logic [MODE_W-1:0] cur);
        logic [MODE_W-1:0] m;
        m = cur;
        unique case (code)
            CODE_MODE0: m = 3'd0;
            CODE_MODE1: m = 3'd1;
            CODE_MODE2: m = 3'd2;
            CODE_MODE3: m = 3'd3;
            CODE_MODE4: m = 3'd4;
            default:    m = cur;
        endcase
        return m;
    endfunction

endpackage

// ----- sv/omfr_cfg.sv -----
// configuration registers for the holdoff gaps
module omfr_cfg
    import omfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [GAP_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_gap <= FRAME_GAP_RESET;
            r_cfg.error_gap <= ERROR_GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_GAP: r_cfg.frame_gap <= i_cfg_data;
                CFG_ERROR_GAP: r_cfg.error_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/omfr_core.sv -----
// receiver state and per-tick update logic
module omfr_core
    import omfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_level,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic              r_rx,   n_rx;
    logic [GAP_W-1:0]  r_ho,   n_ho;
    logic [3:0]        r_ph,   n_ph;
    logic [CODE_W-1:0] r_sh,   n_sh;
    logic [1:0]        r_sm,   n_sm;
    logic [MODE_W-1:0] r_cm,   n_cm;
    logic [MODE_W-1:0] r_pm,   n_pm;

    always_comb begin
        n_rx = r_rx;
        n_ho = r_ho;
        n_ph = r_ph;
        n_sh = r_sh;
        n_sm = r_sm;
        n_cm = r_cm;
        n_pm = r_pm;
        o_result = '0;

        // idle: holdoff, then wait for the low run
        if (!n_rx) begin
            if (n_ho != '0) begin
                n_ho = n_ho - 7'd1;
            end else if (!i_level) begin
                if (n_ph != 4'd0) begin
                    n_ph = n_ph - 4'd1;
                end else begin
                    n_rx = 1'b1;
                    n_ho = '0;
                    n_sm = '0;
                end
            end else begin
                n_ph = DECIDE_PHASE;
            end
        end

        if (n_rx) begin
            if (n_ph == DECIDE_PHASE) begin
                n_ho = n_ho + 7'd1;
                if (n_ho >= FRAME_BITS) begin
                    n_ho = i_cfg.frame_gap;
                    n_rx = 1'b0;
                    n_ph = ABORT_PHASE;
                    o_result.frame_done    = 1'b1;
                    o_result.received_code = n_sh;
                    n_cm = f_decode_mode(n_sh, n_cm);
                    o_result.wake = (n_sh == CODE_WAKE) || (n_pm != n_cm);
                    n_pm = n_cm;
                    n_sh = '0;
                end else begin
                    n_sh = {n_sh[CODE_W-2:0], 1'b0};
                end
            end
            n_ph = n_ph + 4'd1;
            if (n_rx) begin
                if (n_ph <= DECIDE_PHASE) begin
                    n_sm = n_sm + {1'b0, i_level};
                    if (n_ph == DECIDE_PHASE) begin
                        if (n_sm == ALL_HIGH) begin
                            n_sh[0] = 1'b1;
                        end else if (n_sm == 2'd0) begin
                            n_sh[0] = 1'b0;
                        end else begin
                            n_ho = i_cfg.error_gap;
                            n_rx = 1'b0;
                            n_ph = ABORT_PHASE;
                            n_sm = '0;
                            o_result.bit_error = 1'b1;
                        end
                    end
                end else begin
                    n_sm = '0;
                end
            end
            if (n_ph == BIT_TICKS) begin
                n_ph = 4'd0;
            end
        end

        o_result.mode = n_cm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx <= 1'b0;
            r_ho <= '0;
            r_ph <= '0;
            r_sh <= '0;
            r_sm <= '0;
            r_cm <= '0;
            r_pm <= '0;
        end else if (i_step) begin
            r_rx <= n_rx;
            r_ho <= n_ho;
            r_ph <= n_ph;
            r_sh <= n_sh;
            r_sm <= n_sm;
            r_cm <= n_cm;
            r_pm <= n_pm;
        end
    end

endmodule

// ----- sv/oversampled_mode_frame_receiver_unit.sv -----
// top level of the oversampled mode frame receiver
// One line sample word is taken per clock while o_in_stall is low and gives
// one result word. A sample is held in an input register, run through the
// receiver update logic and the result is stored in an output register;
// a new word can be accepted every cycle unless stalled. The input register
// doubles as a skid stage: one more word is taken while a result waits on
// a stalled output. The gap registers should be written only while idle.
`include "oversampled_mode_frame_receiver_unit_defines.svh"
module oversampled_mode_frame_receiver_unit
    import omfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_line_level,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [MODE_W-1:0] o_mode,
    output logic              o_wake,
    output logic              o_frame_done,
    output logic              o_bit_error,
    output logic [CODE_W-1:0] o_received_code,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [GAP_W-1:0]  i_cfg_data
);

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_out;
    logic    r_in_valid;
    logic    r_in_level;
    logic    r_out_valid;
    logic    w_advance;
    logic    w_in_take;

    omfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    omfr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_level  (r_in_level),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_level <= i_line_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mode          = r_out.mode;
    assign o_wake          = r_out.wake;
    assign o_frame_done    = r_out.frame_done;
    assign o_bit_error     = r_out.bit_error;
    assign o_received_code = r_out.received_code;

    `OMFR_ASSERT_IMP(a_done_err_excl, i_clk, i_rst_n, r_out_valid, !(r_out.frame_done && r_out.bit_error))
    `OMFR_ASSERT_IMP(a_code_only_done, i_clk, i_rst_n, r_out_valid && !r_out.frame_done, r_out.received_code == '0)
    `OMFR_ASSERT_IMP(a_mode_range, i_clk, i_rst_n, r_out_valid, r_out.mode <= MODE_MAX)
    `OMFR_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_in_valid && o_in_stall, r_in_valid)

endmodule
